[rtl/tvbb_pkg.sv]
// shared types and constants of the transformed vertex bounding box
package tvbb_pkg;

  // fixed-point formats
  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned ROW_W   = 3 * COEF_W;
  localparam int unsigned PROD_W  = COORD_W + COEF_W;
  localparam int unsigned ACC_W   = PROD_W + 3;
  localparam int unsigned FRAC_SH = 14;
  localparam int unsigned AXES    = 3;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]   ROUND_HALF = 51'sd8192;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_e;

  localparam logic [ROW_W-1:0] ROW_X_RST = 48'h4000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h0000_0000_4000;

  typedef struct packed {
    logic signed [COORD_W-1:0] local_x;
    logic signed [COORD_W-1:0] local_y;
    logic signed [COORD_W-1:0] local_z;
    logic                      last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  // model transform: rows [0]=x [1]=y [2]=z
  typedef struct packed {
    logic [AXES-1:0][ROW_W-1:0]   rows;
    logic [AXES-1:0][COORD_W-1:0] shifts;
  } xform_t;

  // world-space vertex handed from the transform to the bounds tracker
  typedef struct packed {
    logic                                valid;
    logic                                last;
    logic [AXES-1:0][COORD_W-1:0]        coord;
  } world_t;

endpackage

[rtl/tvbb_if.sv]
// valid/ready channel interfaces for vertices, bounds and configuration writes
interface tvbb_vtx_if;
  logic              valid;
  logic              ready;
  tvbb_pkg::vertex_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tvbb_box_if;
  logic           valid;
  logic           ready;
  tvbb_pkg::box_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tvbb_cfg_if;
  logic           valid;
  logic           ready;
  tvbb_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/tvbb_transform.sv]
// three-stage affine transform: input register, products, rounded and saturated sums
module tvbb_transform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  tvbb_pkg::vertex_t in_data_i,
  input  tvbb_pkg::xform_t  xform_i,
  output tvbb_pkg::world_t  world_o
);
  import tvbb_pkg::*;

  logic                               s1_valid_q;
  vertex_t                            s1_vtx_q;
  logic [AXES-1:0][COORD_W-1:0]       s1_coord;

  logic                               s2_valid_q;
  logic                               s2_last_q;
  logic signed [PROD_W-1:0]           prod_d [AXES][AXES];
  logic signed [PROD_W-1:0]           prod_q [AXES][AXES];

  logic [AXES-1:0][COORD_W-1:0]       world_d;
  logic [AXES-1:0][COORD_W-1:0]       world_q;
  logic                               s3_valid_q;
  logic                               s3_last_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_i) begin
      s1_vtx_q <= in_data_i;
    end
  end

  assign s1_coord[0] = s1_vtx_q.local_x;
  assign s1_coord[1] = s1_vtx_q.local_y;
  assign s1_coord[2] = s1_vtx_q.local_z;

  // nine independent Q2.14 x Q16.16 products
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c < AXES; c++) begin
        prod_d[r][c] = $signed(xform_i.rows[r][ROW_W-1-COEF_W*c -: COEF_W])
                     * $signed(s1_coord[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_valid_q) begin
      s2_last_q <= s1_vtx_q.last_vertex;
      prod_q    <= prod_d;
    end
  end

  // sum with translation, round half up to Q16.16, saturate
  always_comb begin
    logic signed [ACC_W-1:0]         acc;
    logic signed [ACC_W-FRAC_SH-1:0] q;
    for (int r = 0; r < AXES; r++) begin
      acc = {{(ACC_W-PROD_W){prod_q[r][0][PROD_W-1]}}, prod_q[r][0]}
          + {{(ACC_W-PROD_W){prod_q[r][1][PROD_W-1]}}, prod_q[r][1]}
          + {{(ACC_W-PROD_W){prod_q[r][2][PROD_W-1]}}, prod_q[r][2]}
          + {{(ACC_W-COORD_W-FRAC_SH){xform_i.shifts[r][COORD_W-1]}},
             xform_i.shifts[r], {FRAC_SH{1'b0}}}
          + ROUND_HALF;
      q = acc[ACC_W-1:FRAC_SH];
      if (q[ACC_W-FRAC_SH-1:COORD_W-1] == {(ACC_W-FRAC_SH-COORD_W+1){q[COORD_W-1]}}) begin
        world_d[r] = q[COORD_W-1:0];
      end else if (q[ACC_W-FRAC_SH-1]) begin
        world_d[r] = Q_MIN;
      end else begin
        world_d[r] = Q_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s2_valid_q) begin
      s3_last_q <= s2_last_q;
      world_q   <= world_d;
    end
  end

  assign world_o.valid = s3_valid_q;
  assign world_o.last  = s3_last_q;
  assign world_o.coord = world_q;

endmodule

[rtl/tvbb_bounds.sv]
// running per-axis min/max with the result register toward the bounds channel
module tvbb_bounds (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tvbb_pkg::world_t world_i,
  output logic             stall_o,
  tvbb_box_if.source       box_o
);
  import tvbb_pkg::*;

  logic                         first_q;
  logic [AXES-1:0][COORD_W-1:0] low_q, low_d;
  logic [AXES-1:0][COORD_W-1:0] high_q, high_d;
  logic                         box_valid_q;
  box_t                         box_q;
  logic                         upd;
  logic                         emit;

  // a last vertex cannot retire while the previous box is still untaken
  assign stall_o = world_i.valid && world_i.last && box_valid_q && !box_o.ready;
  assign upd     = world_i.valid && !stall_o;
  assign emit    = upd && world_i.last;

  // compare against running bounds, or seed on the first vertex
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (first_q) begin
        low_d[a]  = world_i.coord[a];
        high_d[a] = world_i.coord[a];
      end else begin
        low_d[a]  = ($signed(world_i.coord[a]) < $signed(low_q[a]))
                  ? world_i.coord[a] : low_q[a];
        high_d[a] = ($signed(world_i.coord[a]) > $signed(high_q[a]))
                  ? world_i.coord[a] : high_q[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      low_q   <= '0;
      high_q  <= '0;
    end else if (upd) begin
      first_q <= world_i.last;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_valid_q <= 1'b0;
    end else if (emit) begin
      box_valid_q <= 1'b1;
    end else if (box_o.ready) begin
      box_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      box_q.min_x <= low_d[0];
      box_q.min_y <= low_d[1];
      box_q.min_z <= low_d[2];
      box_q.max_x <= high_d[0];
      box_q.max_y <= high_d[1];
      box_q.max_z <= high_d[2];
    end
  end

  assign box_o.valid = box_valid_q;
  assign box_o.data  = box_q;

endmodule

[rtl/transformed_vertex_bounding_box.sv]
// top level: configuration registers, transform pipeline and bounds tracker
// Accepts one vertex per clock and maps it to world space with the 3x3 Q2.14
// matrix and Q16.16 translation held in the configuration registers, then folds
// it into running per-axis min/max. The box of a mesh appears on the bounds
// channel after its last vertex has gone through the input register, product
// register, rounded-sum register and result register. The rate is one vertex
// per cycle; the vertex channel drops ready only while a last vertex sits at
// the bounds tracker and the previous box has not been taken. Configuration
// writes are always ready and apply at once, also to vertices in flight;
// write only while idle.
module transformed_vertex_bounding_box (
  input  logic        clk_i,
  input  logic        rst_ni,
  tvbb_vtx_if.sink    vtx_i,
  tvbb_box_if.source  box_o,
  tvbb_cfg_if.sink    cfg_i
);
  import tvbb_pkg::*;

  logic [ROW_W-1:0]   row_x_q, row_y_q, row_z_q;
  logic [COORD_W-1:0] shift_x_q, shift_y_q, shift_z_q;
  xform_t             xform;
  world_t             world;
  logic               stall;
  logic               en;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q   <= ROW_X_RST;
      row_y_q   <= ROW_Y_RST;
      row_z_q   <= ROW_Z_RST;
      shift_x_q <= '0;
      shift_y_q <= '0;
      shift_z_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_ROW_X:   row_x_q   <= cfg_i.data.data;
        REG_ROW_Y:   row_y_q   <= cfg_i.data.data;
        REG_ROW_Z:   row_z_q   <= cfg_i.data.data;
        REG_SHIFT_X: shift_x_q <= cfg_i.data.data[COORD_W-1:0];
        REG_SHIFT_Y: shift_y_q <= cfg_i.data.data[COORD_W-1:0];
        REG_SHIFT_Z: shift_z_q <= cfg_i.data.data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign xform.rows[0]   = row_x_q;
  assign xform.rows[1]   = row_y_q;
  assign xform.rows[2]   = row_z_q;
  assign xform.shifts[0] = shift_x_q;
  assign xform.shifts[1] = shift_y_q;
  assign xform.shifts[2] = shift_z_q;

  // whole pipeline advances unless a box is blocked
  assign en          = !stall;
  assign vtx_i.ready = en;

  tvbb_transform u_transform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (vtx_i.valid),
    .in_data_i  (vtx_i.data),
    .xform_i    (xform),
    .world_o    (world)
  );

  tvbb_bounds u_bounds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .world_i (world),
    .stall_o (stall),
    .box_o   (box_o)
  );

  // checks
  a_stall_only_on_held_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vtx_i.ready |-> (box_o.valid && !box_o.ready))
    else $error("vertex channel stalled without a held box");

  a_box_from_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(box_o.valid) |-> $past(world.valid && world.last))
    else $error("box appeared without a last vertex");

  a_box_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (box_o.valid && box_o.ready && !(world.valid && world.last)) |=> !box_o.valid)
    else $error("taken box stayed valid with no new last vertex");

endmodule
